// ===== hw/rtl/arl_pkg.sv =====
// Shared constants, types and state codes of the address-to-range lookup unit.
`timescale 1ns / 1ps
`default_nettype none
package arl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 64;
    localparam int SLOT_W      = 10;
    localparam int CFG_W       = 11;
    localparam int RIDX_W      = 10;

    localparam int S_TDATA_W   = 208;
    localparam int M_TDATA_W   = 16;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_FINISH
    } arl_state_t;

    typedef struct packed {
        logic              hit;
        logic [RIDX_W-1:0] index;
    } arl_result_t;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] address;
    } arl_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/address_to_range_lookup_unit.sv =====
// Top level of the address-to-range lookup unit: ports, config register, output register.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   s_* carries items in: s_tuser = 0 loads one table slot (start, end), s_tuser = 1
//   looks up an address. A load gives no result; a lookup gives one item on m_*.
//   cfg_* writes entries_in_use, the count of sorted slots searched; write it only
//   while the unit is idle. cfg_ready is always high.
// Sequence:
//   A load is taken while the unit is idle and leaves it idle. A lookup does one
//   table read and one 64-bit compare per probe of a binary search over the slots
//   in use, then an end-of-range check, and then hands its result to the output
//   register; the unit takes no new item until that handover. A search with no
//   candidate skips the check; a count of 0 skips the probes and the check as well.
// Reset clears the control state and entries_in_use; table contents stay undefined
// until loaded. While the receiver stalls, a finished result waits in the output
// register and the unit keeps taking items; a second result then waits in the
// sequencer, which holds s_tready low until the output register frees.
module address_to_range_lookup_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: entry_index[9:0], range_start[73:10], range_end[137:74],
    //          lookup_address[201:138], zero [207:202]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [arl_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind[0]
    input  wire logic                          s_tuser,
    // m_tdata: hit[0], range_index[10:1], zero [15:11]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [arl_pkg::M_TDATA_W-1:0] m_tdata,
    // cfg_data: entries_in_use[10:0]
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [arl_pkg::CFG_W-1:0]     cfg_data
);

    logic [arl_pkg::CFG_W-1:0]  count_cfg_reg;
    logic [arl_pkg::CNT_W-1:0]  search_count;

    logic [arl_pkg::SLOT_W-1:0] in_slot;
    logic [arl_pkg::ADDR_W-1:0] in_start, in_end, in_addr;
    logic                       s_accept;

    logic                       wr_en;
    logic [arl_pkg::IDX_W-1:0]  rd_addr;
    logic [arl_pkg::ADDR_W-1:0] rd_start, rd_end;

    arl_pkg::arl_req_t          req;
    arl_pkg::arl_result_t       res;
    logic                       search_idle, res_valid, res_take;

    logic                       m_valid_reg, m_valid_next;
    arl_pkg::arl_result_t       m_res_reg, m_res_next;

    assign in_slot  = s_tdata[9:0];
    assign in_start = s_tdata[73:10];
    assign in_end   = s_tdata[137:74];
    assign in_addr  = s_tdata[201:138];

    assign cfg_ready = 1'b1;
    assign s_tready  = search_idle;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            count_cfg_reg <= cfg_data;
        end
    end

    // counts beyond the table depth search the whole table
    always_comb begin
        if (32'(count_cfg_reg) > 32'(arl_pkg::TABLE_DEPTH)) begin
            search_count = arl_pkg::CNT_W'(arl_pkg::TABLE_DEPTH);
        end else begin
            search_count = arl_pkg::CNT_W'(count_cfg_reg);
        end
    end

    assign wr_en = s_accept && (s_tuser == arl_pkg::KIND_LOAD)
                   && (32'(in_slot) < 32'(arl_pkg::TABLE_DEPTH));

    always_comb begin
        req.start   = s_accept && (s_tuser == arl_pkg::KIND_LOOKUP);
        req.count   = search_count;
        req.address = in_addr;
    end

    arl_table u_table (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (arl_pkg::IDX_W'(in_slot)),
        .wr_start (in_start),
        .wr_end   (in_end),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    arl_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rd_start  (rd_start),
        .rd_end    (rd_end),
        .rd_addr   (rd_addr),
        .idle      (search_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register
    assign res_take = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_take) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(arl_pkg::M_TDATA_W - arl_pkg::RIDX_W - 1)'(0),
                       m_res_reg.index, m_res_reg.hit};

    // a miss always reports index zero
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[10:1] == '0))
        else $error("miss result with nonzero range_index");

    // a lookup holds s_tready low in the cycle after its accept
    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == arl_pkg::KIND_LOOKUP)) |=> !s_tready)
        else $error("ready high right after lookup accept");

    // a load never produces a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == arl_pkg::KIND_LOAD) && !m_tvalid)
        |=> !m_tvalid)
        else $error("result appeared after a load item");

endmodule
`default_nettype wire

// ===== hw/rtl/arl_table.sv =====
// Range table storage: start and end arrays, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module arl_table (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [arl_pkg::IDX_W-1:0]  wr_addr,
    input  wire logic [arl_pkg::ADDR_W-1:0] wr_start,
    input  wire logic [arl_pkg::ADDR_W-1:0] wr_end,
    input  wire logic [arl_pkg::IDX_W-1:0]  rd_addr,
    output logic      [arl_pkg::ADDR_W-1:0] rd_start,
    output logic      [arl_pkg::ADDR_W-1:0] rd_end
);

    logic [arl_pkg::ADDR_W-1:0] start_mem [arl_pkg::TABLE_DEPTH];
    logic [arl_pkg::ADDR_W-1:0] end_mem   [arl_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            end_mem[wr_addr]   <= wr_end;
        end
    end

    always_ff @(posedge aclk) begin
        rd_start <= start_mem[rd_addr];
        rd_end   <= end_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/arl_search.sv =====
// Binary search sequencer: one 64-bit compare per cycle against the table read port.
`timescale 1ns / 1ps
`default_nettype none
module arl_search (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire arl_pkg::arl_req_t          req,
    input  wire logic [arl_pkg::ADDR_W-1:0] rd_start,
    input  wire logic [arl_pkg::ADDR_W-1:0] rd_end,
    output logic      [arl_pkg::IDX_W-1:0]  rd_addr,
    output logic                            idle,
    output logic                            res_valid,
    input  wire logic                       res_take,
    output arl_pkg::arl_result_t            res
);

    arl_pkg::arl_state_t state_reg, state_next;

    logic [arl_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [arl_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [arl_pkg::IDX_W-1:0]  mid_reg, mid_next;
    logic [arl_pkg::ADDR_W-1:0] addr_reg, addr_next;
    arl_pkg::arl_result_t       res_reg, res_next;

    // shared compare and interval update
    logic                      start_le;
    logic [arl_pkg::CNT_W-1:0] hi_upd;
    logic [arl_pkg::CNT_W-1:0] mid_plus;
    logic [arl_pkg::CNT_W-1:0] lo_new;

    // start <= address moves lo past the probed entry, else hi drops to it
    always_comb begin
        start_le = (rd_start <= addr_reg);
        mid_plus = arl_pkg::CNT_W'(mid_reg) + arl_pkg::CNT_W'(1);
        lo_new   = start_le ? mid_plus : lo_reg;
        hi_upd   = start_le ? hi_reg : arl_pkg::CNT_W'(mid_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            arl_pkg::ST_IDLE: begin
                if (req.start) begin
                    state_next = (req.count == '0) ? arl_pkg::ST_FINISH : arl_pkg::ST_PROBE;
                end
            end
            arl_pkg::ST_PROBE: begin
                if (lo_new >= hi_upd) begin
                    state_next = (lo_new == '0) ? arl_pkg::ST_FINISH : arl_pkg::ST_CHECK;
                end
            end
            arl_pkg::ST_CHECK: begin
                state_next = arl_pkg::ST_FINISH;
            end
            arl_pkg::ST_FINISH: begin
                if (res_take) begin
                    state_next = arl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        idle      = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            arl_pkg::ST_IDLE:   idle      = 1'b1;
            arl_pkg::ST_FINISH: res_valid = 1'b1;
            default: begin
                idle      = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        addr_next = addr_reg;
        res_next  = res_reg;
        case (state_reg)
            arl_pkg::ST_IDLE: begin
                mid_next = arl_pkg::IDX_W'(req.count >> 1);
                if (req.start) begin
                    lo_next   = '0;
                    hi_next   = req.count;
                    addr_next = req.address;
                    res_next  = '0;
                end
            end
            arl_pkg::ST_PROBE: begin
                lo_next = lo_new;
                hi_next = hi_upd;
                if (lo_new < hi_upd) begin
                    mid_next = arl_pkg::IDX_W'(lo_new + ((hi_upd - lo_new) >> 1));
                end else begin
                    // candidate is the entry just below lo
                    mid_next = arl_pkg::IDX_W'(lo_new - arl_pkg::CNT_W'(1));
                end
            end
            arl_pkg::ST_CHECK: begin
                res_next.hit   = (addr_reg < rd_end);
                res_next.index = (addr_reg < rd_end) ? arl_pkg::RIDX_W'(mid_reg) : '0;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    assign rd_addr = mid_next;
    assign res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire

// ===== verif/tb_address_to_range_lookup_unit.sv =====
// Self-checking testbench of the address-to-range lookup unit: table loads, lookups, count writes.
`timescale 1ns / 1ps
module tb_address_to_range_lookup_unit;

    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned DRAIN_CYCLES     = 20;
    localparam int unsigned LOOKUPS_PER_SET  = 35;
    localparam int unsigned NUM_SETS         = 16;
    localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOOKUP,
        OP_CONFIG
    } op_t;

    typedef struct {
        op_t                  op;
        logic [9:0]           slot;
        logic [63:0]          a;      // range start, lookup address or count
        logic [63:0]          b;      // range end
        bit                   pinned; // expectation typed in below
        arl_pkg::arl_result_t want;
    } plan_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [arl_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = arl_pkg::KIND_LOAD;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [arl_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [arl_pkg::CFG_W-1:0]      cfg_data  = '0;

    // shadow of the table and count
    logic [63:0]                start_of [arl_pkg::TABLE_DEPTH];
    logic [63:0]                end_of   [arl_pkg::TABLE_DEPTH];
    bit                         loaded   [arl_pkg::TABLE_DEPTH];
    int unsigned                loaded_total = 0;
    logic [arl_pkg::CFG_W-1:0]  slots_in_use = '0;

    arl_pkg::arl_result_t pending_ranges[$];
    arl_pkg::arl_result_t got;
    arl_pkg::arl_result_t oldest;
    plan_row_t            plan[$];
    int unsigned          sender_idle_pct = 0;
    int unsigned          stall_pct       = 0;
    int unsigned          mismatches      = 0;
    int unsigned          cycle_count     = 0;
    int unsigned          set_counts[NUM_SETS] =
        '{1, 0, 2, 7, 33, 1024, 2047, 1023, 16, 1025, 3, 512, 48, 1024, 5, 1};

    address_to_range_lookup_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // last entry whose start is at most addr, hit only below its end
    function automatic arl_pkg::arl_result_t find_range(input logic [63:0] addr);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        arl_pkg::arl_result_t r;
        lo = 0;
        hi = (slots_in_use > arl_pkg::TABLE_DEPTH) ? arl_pkg::TABLE_DEPTH : slots_in_use;
        r  = '0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (start_of[10'(mid)] <= addr) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (lo > 0 && addr < end_of[10'(lo - 1)]) begin
            r.hit   = 1'b1;
            r.index = arl_pkg::RIDX_W'(lo - 1);
        end
        return r;
    endfunction

    function automatic plan_row_t row(input op_t op, input logic [9:0] slot,
                                      input logic [63:0] a, input logic [63:0] b,
                                      input bit pinned, input logic hit,
                                      input logic [9:0] index);
        plan_row_t r;
        r.op         = op;
        r.slot       = slot;
        r.a          = a;
        r.b          = b;
        r.pinned     = pinned;
        r.want.hit   = hit;
        r.want.index = index;
        return r;
    endfunction

    task automatic drive_item(input logic kind,
                              input logic [arl_pkg::S_TDATA_W-1:0] data);
        int unsigned gap;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_load(input logic [9:0] slot, input logic [63:0] rs,
                             input logic [63:0] re);
        drive_item(arl_pkg::KIND_LOAD, {6'd0, rand64(), re, rs, slot});
        start_of[slot] = rs;
        end_of[slot]   = re;
        if (!loaded[slot]) begin
            loaded[slot] = 1'b1;
            loaded_total++;
        end
    endtask

    task automatic send_lookup(input logic [63:0] addr, input bit pinned,
                               input arl_pkg::arl_result_t want);
        drive_item(arl_pkg::KIND_LOOKUP,
                   {6'd0, addr, rand64(), rand64(), 10'($urandom)});
        pending_ranges.push_back(pinned ? want : find_range(addr));
    endtask

    // count changes only once the unit has gone quiet
    task automatic write_count(input logic [arl_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        slots_in_use  = value;
    endtask

    // fresh table of k ascending starts spread over the address space
    task automatic load_sorted(input int unsigned k);
        logic [63:0] span;
        logic [63:0] cur;
        logic [63:0] rs;
        logic [63:0] re;
        span = ALL_ONES / (k + 1);
        cur  = rand64() % span;
        for (int unsigned i = 0; i < k; i++) begin
            rs = cur;
            case ($urandom_range(7))
                0:       re = rs;                        // empty range
                1:       re = rs - rand64() % span;      // inverted range
                default: re = rs + 1 + rand64() % span;
            endcase
            send_load(10'(i), rs, re);
            cur = rs + rand64() % span;
        end
    endtask

    task automatic run_set(input int unsigned count);
        int unsigned k;
        logic [9:0]  j;
        logic [63:0] addr;
        k = (count > arl_pkg::TABLE_DEPTH) ? arl_pkg::TABLE_DEPTH : count;
        if (k <= 64 || loaded_total < arl_pkg::TABLE_DEPTH) begin
            load_sorted(k);
        end
        write_count(arl_pkg::CFG_W'(count));
        for (int unsigned n = 0; n < LOOKUPS_PER_SET; n++) begin
            // stray loads, some of them break the ordering
            if ($urandom_range(99) < 8) begin
                send_load(10'($urandom), rand64(), rand64());
            end
            if (k == 0) begin
                addr = rand64();
            end else begin
                j = 10'($urandom_range(k - 1));
                case ($urandom_range(6))
                    0: addr = start_of[j];
                    1: addr = (end_of[j] > start_of[j])
                            ? start_of[j] + rand64() % (end_of[j] - start_of[j])
                            : start_of[j];
                    2: addr = end_of[j] - 1;
                    3: addr = end_of[j];
                    4: addr = start_of[j] - 1;
                    default: addr = rand64();
                endcase
            end
            send_lookup(addr, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.hit   = m_tdata[0];
            got.index = m_tdata[10:1];
            if (pending_ranges.size() == 0) begin
                $error("result item with nothing expected, m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                oldest = pending_ranges.pop_front();
                if (got.hit !== oldest.hit) begin
                    $error("hit: expected %0d, actual %0d", oldest.hit, got.hit);
                    mismatches++;
                end
                if (got.index !== oldest.index) begin
                    $error("range_index: expected %0d, actual %0d", oldest.index, got.index);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // empty table first, then a small hand-built table
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'd0, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, ALL_ONES, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOAD, 10'd0, 64'h10, 64'h100, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOAD, 10'd1, 64'h1000, 64'h1000, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOAD, 10'd2, 64'h2000, 64'h1800, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOAD, 10'd3, 64'h8000_0000_0000_0000, ALL_ONES,
                           1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOAD, 10'd1023, ALL_ONES, ALL_ONES, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_CONFIG, 10'd0, 64'd4, 64'd0, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'd0, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h10, 64'd0, 1'b1, 1'b1, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'hFF, 64'd0, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h100, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h1000, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h2000, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h8000_0000_0000_0000, 64'd0,
                           1'b1, 1'b1, 10'd3));
        plan.push_back(row(OP_LOOKUP, 10'd0, ALL_ONES, 64'd0, 1'b1, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, ALL_ONES - 64'd1, 64'd0, 1'b1, 1'b1, 10'd3));
        // slot 1 now out of order
        plan.push_back(row(OP_LOAD, 10'd1, 64'h9000_0000_0000_0000, ALL_ONES,
                           1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h2000, 64'd0, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h9000_0000_0000_0005, 64'd0,
                           1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h0000_0000_0000_0050, 64'd0,
                           1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_CONFIG, 10'd0, 64'd1, 64'd0, 1'b0, 1'b0, 10'd0));
        plan.push_back(row(OP_LOOKUP, 10'd0, 64'h8000_0000_0000_0000, 64'd0,
                           1'b0, 1'b0, 10'd0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].op)
                OP_LOAD:   send_load(plan[i].slot, plan[i].a, plan[i].b);
                OP_LOOKUP: send_lookup(plan[i].a, plan[i].pinned, plan[i].want);
                default:   write_count(plan[i].a[arl_pkg::CFG_W-1:0]);
            endcase
        end

        for (int unsigned p = 0; p < NUM_SETS; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 50; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 50; end
                default: begin sender_idle_pct = 29; stall_pct = 29; end
            endcase
            run_set(set_counts[4'(p)]);
        end

        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
